@@ rtl/lattice_boltzmann_d2q4_collide_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef LATTICE_BOLTZMANN_D2Q4_COLLIDE_ASSERT_SVH
`define LATTICE_BOLTZMANN_D2Q4_COLLIDE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LBD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbd2q4 check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LBD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbd2q4 check failed");

`endif

@@ rtl/lbd2q4_pkg.sv @@
package lbd2q4_pkg;

	localparam int DIST_WIDTH_DEF = 32;
	localparam int VEL_WIDTH      = 16;
	localparam int ITAU_WIDTH     = 17;
	localparam int FACT_WIDTH     = 17;
	localparam int FRAC_SHIFT     = 16;

	localparam logic [ITAU_WIDTH-1:0] ITAU_RESET      = 17'd65536;
	localparam logic signed [FACT_WIDTH-1:0] HALF_Q15 = 17'sd16384;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} lbd2q4_ctl_t;

endpackage

@@ rtl/lbd2q4_lane.sv @@
module lbd2q4_lane #(
	parameter int DIST_WIDTH = lbd2q4_pkg::DIST_WIDTH_DEF
) (
	input  logic                                          clk,
	input  lbd2q4_pkg::lbd2q4_ctl_t                       ctl,
	input  logic signed [DIST_WIDTH-1:0]                  dist_s1,
	input  logic signed [lbd2q4_pkg::FACT_WIDTH-1:0]      factor_s1,
	input  logic signed [DIST_WIDTH+1:0]                  conc_s1,
	input  logic [lbd2q4_pkg::ITAU_WIDTH-1:0]             itau,
	output logic signed [DIST_WIDTH-1:0]                  slot_s5,
	output logic                                          sat_s5
);

	localparam int CW  = DIST_WIDTH + 2;
	localparam int PW1 = CW + lbd2q4_pkg::FACT_WIDTH;
	localparam int EW  = PW1 - lbd2q4_pkg::FRAC_SHIFT;
	localparam int DFW = EW + 1;
	localparam int MW  = lbd2q4_pkg::ITAU_WIDTH + 1;
	localparam int PW2 = DFW + MW;
	localparam int SW  = PW2 - lbd2q4_pkg::FRAC_SHIFT;
	localparam int RW  = SW + 1;
	localparam int HW  = RW - DIST_WIDTH + 1;

	localparam logic signed [PW1-1:0] RND1 = PW1'(1) <<< (lbd2q4_pkg::FRAC_SHIFT - 1);
	localparam logic signed [PW2-1:0] RND2 = PW2'(1) <<< (lbd2q4_pkg::FRAC_SHIFT - 1);
	localparam logic signed [DIST_WIDTH-1:0] DMAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
	localparam logic signed [DIST_WIDTH-1:0] DMIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

	logic signed [PW1-1:0]        prod1;
	logic signed [PW2-1:0]        prod2;
	logic signed [MW-1:0]         itau_sgn;
	logic signed [RW-1:0]         sum;
	logic [HW-1:0]                sum_hi;
	logic                         ovf;

	logic signed [DIST_WIDTH-1:0] dist_s2, dist_s3, dist_s4;
	logic signed [EW-1:0]         eq_s2;
	logic signed [DFW-1:0]        diff_s3;
	logic signed [SW-1:0]         step_s4;

	assign itau_sgn = $signed({1'b0, itau});
	assign prod1    = PW1'(conc_s1) * PW1'(factor_s1) + RND1;
	assign prod2    = PW2'(diff_s3) * PW2'(itau_sgn) + RND2;
	assign sum      = RW'(dist_s4) + RW'(step_s4);
	assign sum_hi   = sum[RW-1:DIST_WIDTH-1];
	assign ovf      = !((&sum_hi) || !(|sum_hi));

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			dist_s2 <= dist_s1;
			eq_s2   <= prod1[PW1-1:lbd2q4_pkg::FRAC_SHIFT];
		end
		if (ctl.en_s3) begin
			dist_s3 <= dist_s2;
			diff_s3 <= DFW'(eq_s2) - DFW'(dist_s2);
		end
		if (ctl.en_s4) begin
			dist_s4 <= dist_s3;
			step_s4 <= prod2[PW2-1:lbd2q4_pkg::FRAC_SHIFT];
		end
		if (ctl.en_s5) begin
			sat_s5  <= ovf;
			slot_s5 <= ovf ? (sum[RW-1] ? DMIN : DMAX) : sum[DIST_WIDTH-1:0];
		end
	end

endmodule

@@ rtl/lattice_boltzmann_d2q4_collide.sv @@
// channel | handshake              | payload
// node    | node_valid/node_stall  | dist_east/north/west/south, vel_x, vel_y
// slot    | slot_valid/slot_stall  | slot_east/north/west/south, concentration, saturated
// cfg     | cfg_we                 | cfg_wdata (inverse tau, Q1.16)
//
// One node per cycle while node_stall is low; slot_valid rises as a node reaches s5.
// Stages: sum and factors, equilibrium multiply, difference, relaxation multiply,
// add with saturation and swap. Each stage advances when empty or when the stage
// after it moves, so bubbles fill while slot_stall is high.
// arst_n clears all stage valid bits and sets inverse tau to one.
module lattice_boltzmann_d2q4_collide #(
	parameter int DIST_WIDTH = lbd2q4_pkg::DIST_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        node_valid,
	output logic                                        node_stall,
	input  logic signed [DIST_WIDTH-1:0]                dist_east,
	input  logic signed [DIST_WIDTH-1:0]                dist_north,
	input  logic signed [DIST_WIDTH-1:0]                dist_west,
	input  logic signed [DIST_WIDTH-1:0]                dist_south,
	input  logic signed [lbd2q4_pkg::VEL_WIDTH-1:0]     vel_x,
	input  logic signed [lbd2q4_pkg::VEL_WIDTH-1:0]     vel_y,
	output logic                                        slot_valid,
	input  logic                                        slot_stall,
	output logic signed [DIST_WIDTH-1:0]                slot_east,
	output logic signed [DIST_WIDTH-1:0]                slot_north,
	output logic signed [DIST_WIDTH-1:0]                slot_west,
	output logic signed [DIST_WIDTH-1:0]                slot_south,
	output logic signed [DIST_WIDTH+1:0]                concentration,
	output logic                                        saturated,
	input  logic                                        cfg_we,
	input  logic [lbd2q4_pkg::ITAU_WIDTH-1:0]           cfg_wdata
);

	localparam int CW = DIST_WIDTH + 2;
	localparam int FW = lbd2q4_pkg::FACT_WIDTH;

	logic [lbd2q4_pkg::ITAU_WIDTH-1:0] itau_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	lbd2q4_pkg::lbd2q4_ctl_t ctl;

	logic signed [DIST_WIDTH-1:0] de_s1, dn_s1, dw_s1, ds_s1;
	logic signed [FW-1:0]         fe_s1, fn_s1, fw_s1, fs_s1;
	logic signed [CW-1:0]         conc_s1, conc_s2, conc_s3, conc_s4, conc_s5;
	logic signed [FW-1:0]         ux, uy;

	logic signed [DIST_WIDTH-1:0] re_s5, rn_s5, rw_s5, rs_s5;
	logic                         se_s5, sn_s5, sw_s5, ss_s5;

	assign rdy_s5 = !v_s5 || !slot_stall;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign node_stall = !rdy_s1;

	assign ctl.en_s2 = rdy_s2;
	assign ctl.en_s3 = rdy_s3;
	assign ctl.en_s4 = rdy_s4;
	assign ctl.en_s5 = rdy_s5;

	assign ux = FW'(vel_x);
	assign uy = FW'(vel_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itau_q <= lbd2q4_pkg::ITAU_RESET;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
		end else begin
			if (cfg_we)
				itau_q <= cfg_wdata;
			if (rdy_s1)
				v_s1 <= node_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_s3)
				v_s3 <= v_s2;
			if (rdy_s4)
				v_s4 <= v_s3;
			if (rdy_s5)
				v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			de_s1   <= dist_east;
			dn_s1   <= dist_north;
			dw_s1   <= dist_west;
			ds_s1   <= dist_south;
			fe_s1   <= lbd2q4_pkg::HALF_Q15 + ux;
			fn_s1   <= lbd2q4_pkg::HALF_Q15 + uy;
			fw_s1   <= lbd2q4_pkg::HALF_Q15 - ux;
			fs_s1   <= lbd2q4_pkg::HALF_Q15 - uy;
			conc_s1 <= CW'(dist_east) + CW'(dist_north) + CW'(dist_west) + CW'(dist_south);
		end
		if (rdy_s2)
			conc_s2 <= conc_s1;
		if (rdy_s3)
			conc_s3 <= conc_s2;
		if (rdy_s4)
			conc_s4 <= conc_s3;
		if (rdy_s5)
			conc_s5 <= conc_s4;
	end

	lbd2q4_lane #(.DIST_WIDTH(DIST_WIDTH)) u_lane_e (
		.clk(clk), .ctl(ctl), .dist_s1(de_s1), .factor_s1(fe_s1), .conc_s1(conc_s1),
		.itau(itau_q), .slot_s5(re_s5), .sat_s5(se_s5)
	);

	lbd2q4_lane #(.DIST_WIDTH(DIST_WIDTH)) u_lane_n (
		.clk(clk), .ctl(ctl), .dist_s1(dn_s1), .factor_s1(fn_s1), .conc_s1(conc_s1),
		.itau(itau_q), .slot_s5(rn_s5), .sat_s5(sn_s5)
	);

	lbd2q4_lane #(.DIST_WIDTH(DIST_WIDTH)) u_lane_w (
		.clk(clk), .ctl(ctl), .dist_s1(dw_s1), .factor_s1(fw_s1), .conc_s1(conc_s1),
		.itau(itau_q), .slot_s5(rw_s5), .sat_s5(sw_s5)
	);

	lbd2q4_lane #(.DIST_WIDTH(DIST_WIDTH)) u_lane_s (
		.clk(clk), .ctl(ctl), .dist_s1(ds_s1), .factor_s1(fs_s1), .conc_s1(conc_s1),
		.itau(itau_q), .slot_s5(rs_s5), .sat_s5(ss_s5)
	);

	// swap opposite directions ahead of streaming
	assign slot_valid    = v_s5;
	assign slot_east     = rw_s5;
	assign slot_north    = rs_s5;
	assign slot_west     = re_s5;
	assign slot_south    = rn_s5;
	assign concentration = conc_s5;
	assign saturated     = se_s5 || sn_s5 || sw_s5 || ss_s5;

endmodule

@@ rtl/lbd2q4_chk.sv @@
`include "lattice_boltzmann_d2q4_collide_assert.svh"

module lbd2q4_chk #(
	parameter int DIST_WIDTH = lbd2q4_pkg::DIST_WIDTH_DEF
) (
	input logic                                        clk,
	input logic                                        arst_n,
	input logic                                        node_valid,
	input logic                                        node_stall,
	input logic signed [DIST_WIDTH-1:0]                dist_east,
	input logic signed [DIST_WIDTH-1:0]                dist_north,
	input logic signed [DIST_WIDTH-1:0]                dist_west,
	input logic signed [DIST_WIDTH-1:0]                dist_south,
	input logic signed [lbd2q4_pkg::VEL_WIDTH-1:0]     vel_x,
	input logic signed [lbd2q4_pkg::VEL_WIDTH-1:0]     vel_y,
	input logic                                        slot_valid,
	input logic                                        slot_stall,
	input logic signed [DIST_WIDTH-1:0]                slot_east,
	input logic signed [DIST_WIDTH-1:0]                slot_north,
	input logic signed [DIST_WIDTH-1:0]                slot_west,
	input logic signed [DIST_WIDTH-1:0]                slot_south,
	input logic signed [DIST_WIDTH+1:0]                concentration,
	input logic                                        saturated
);

	localparam logic signed [DIST_WIDTH-1:0] DMAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
	localparam logic signed [DIST_WIDTH-1:0] DMIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

	logic east_edge, north_edge, west_edge, south_edge;
	logic any_edge;
	logic [5*DIST_WIDTH+2:0] slot_bus;
	logic [4*DIST_WIDTH+2*lbd2q4_pkg::VEL_WIDTH-1:0] node_bus;

	assign east_edge  = (slot_east == DMAX) || (slot_east == DMIN);
	assign north_edge = (slot_north == DMAX) || (slot_north == DMIN);
	assign west_edge  = (slot_west == DMAX) || (slot_west == DMIN);
	assign south_edge = (slot_south == DMAX) || (slot_south == DMIN);
	assign any_edge   = east_edge || north_edge || west_edge || south_edge;
	assign slot_bus   = {slot_east, slot_north, slot_west, slot_south, concentration, saturated};
	assign node_bus   = {dist_east, dist_north, dist_west, dist_south, vel_x, vel_y};

	`LBD_ASSERT_NXT(a_slot_hold, slot_valid && slot_stall, slot_valid && $stable(slot_bus))
	`LBD_ASSERT_IMP(a_sat_clipped, slot_valid && saturated, any_edge)
	`LBD_ASSERT_IMP(a_no_stall_empty, !slot_valid, !node_stall)
	`LBD_ASSERT_NXT(a_node_hold, node_valid && node_stall, node_valid && $stable(node_bus))

endmodule

bind lattice_boltzmann_d2q4_collide lbd2q4_chk #(.DIST_WIDTH(DIST_WIDTH)) u_lbd2q4_chk (.*);

@@ dv/lattice_boltzmann_d2q4_collide_tb.sv @@
module lattice_boltzmann_d2q4_collide_tb;

	localparam int DW = lbd2q4_pkg::DIST_WIDTH_DEF;
	localparam int VW = lbd2q4_pkg::VEL_WIDTH;
	localparam int ITW = lbd2q4_pkg::ITAU_WIDTH;
	localparam longint DIST_MAX = (longint'(1) <<< (DW - 1)) - 1;
	localparam longint DIST_MIN = -DIST_MAX - 1;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic signed [DW-1:0] e;
		logic signed [DW-1:0] n;
		logic signed [DW-1:0] w;
		logic signed [DW-1:0] s;
		logic signed [VW-1:0] u;
		logic signed [VW-1:0] v;
	} node_t;

	typedef struct packed {
		logic signed [DW-1:0] east;
		logic signed [DW-1:0] north;
		logic signed [DW-1:0] west;
		logic signed [DW-1:0] south;
		logic signed [DW+1:0] conc;
		logic sat;
	} slots_t;

	typedef struct packed {
		node_t node;
		logic typed;
		slots_t want;
	} node_row_t;

	logic clk;
	logic arst_n;
	logic node_valid;
	logic node_stall;
	logic signed [DW-1:0] dist_east;
	logic signed [DW-1:0] dist_north;
	logic signed [DW-1:0] dist_west;
	logic signed [DW-1:0] dist_south;
	logic signed [VW-1:0] vel_x;
	logic signed [VW-1:0] vel_y;
	logic slot_valid;
	logic slot_stall;
	logic signed [DW-1:0] slot_east;
	logic signed [DW-1:0] slot_north;
	logic signed [DW-1:0] slot_west;
	logic signed [DW-1:0] slot_south;
	logic signed [DW+1:0] concentration;
	logic saturated;
	logic cfg_we;
	logic [ITW-1:0] cfg_wdata;

	slots_t pending_slots[$];
	logic [ITW-1:0] itau_now = lbd2q4_pkg::ITAU_RESET;
	int mismatch_count = 0;
	int idle_pct = 17;
	bit hold_req = 0;

	node_row_t node_rows [20] = '{
		'{'{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 16'h0000, 16'h0000},
			1'b1, '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 34'h0, 1'b0}},
		'{'{32'h01000000, 32'h01000000, 32'h01000000, 32'h01000000, 16'h0000, 16'h0000},
			1'b1, '{32'h01000000, 32'h01000000, 32'h01000000, 32'h01000000,
			34'h004000000, 1'b0}},
		'{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000, 16'h0000},
			1'b1, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			34'h1FFFFFFFC, 1'b0}},
		'{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 16'h0000, 16'h0000},
			1'b1, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			34'h200000000, 1'b0}},
		'{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h8000, 16'h0000},
			1'b1, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000001, 32'h7FFFFFFF,
			34'h1FFFFFFFC, 1'b1}},
		'{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000, 16'h8000},
			1'b1, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000001,
			34'h1FFFFFFFC, 1'b1}},
		'{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h0000},
			1'b1, '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			34'h200000000, 1'b1}},
		'{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF},
			1'b0, '0},
		'{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 16'h7FFF, 16'h8000},
			1'b0, '0},
		'{'{32'h7FFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000, 16'h7FFF, 16'h0000},
			1'b0, '0},
		'{'{32'h00000000, 32'h80000000, 32'h00000000, 32'h00000000, 16'h0000, 16'h8000},
			1'b0, '0},
		'{'{32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555, 32'h55555555, 16'hAAAA, 16'h5555},
			1'b0, '0},
		'{'{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA},
			1'b0, '0},
		'{'{32'hFF000000, 32'h01000000, 32'hFE000000, 32'h00800000, 16'h1000, 16'hF000},
			1'b0, '0},
		'{'{32'h00000001, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 16'h0001, 16'hFFFF},
			1'b0, '0},
		'{'{32'h00400000, 32'h00400000, 32'h00400000, 32'h00400000, 16'h2000, 16'hE000},
			1'b0, '0},
		'{'{32'h01000000, 32'h00000000, 32'h00000000, 32'h00000000, 16'h4000, 16'hC000},
			1'b0, '0},
		'{'{32'h12345678, 32'h0ABCDEF0, 32'h00F0F0F0, 32'h07654321, 16'h0123, 16'hFEDC},
			1'b0, '0},
		'{'{32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 16'h4000, 16'h0000},
			1'b0, '0},
		'{'{32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000, 16'h4000, 16'h0000},
			1'b0, '0}
	};

	lattice_boltzmann_d2q4_collide #(
		.DIST_WIDTH(DW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.node_valid(node_valid),
		.node_stall(node_stall),
		.dist_east(dist_east),
		.dist_north(dist_north),
		.dist_west(dist_west),
		.dist_south(dist_south),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.slot_valid(slot_valid),
		.slot_stall(slot_stall),
		.slot_east(slot_east),
		.slot_north(slot_north),
		.slot_west(slot_west),
		.slot_south(slot_south),
		.concentration(concentration),
		.saturated(saturated),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint round_q16(longint a, longint m);
		return (a * m + 32768) >>> 16;
	endfunction

	function automatic longint relax_dist(longint f, longint c, longint factor, longint itau,
			inout bit sat);
		longint eq;
		longint x;
		eq = round_q16(c, factor);
		x = f + round_q16(eq - f, itau);
		if (x > DIST_MAX) begin
			sat = 1'b1;
			x = DIST_MAX;
		end else if (x < DIST_MIN) begin
			sat = 1'b1;
			x = DIST_MIN;
		end
		return x;
	endfunction

	function automatic slots_t collide_node(node_t nd, logic [ITW-1:0] itau);
		slots_t r;
		longint c;
		longint t;
		longint half;
		longint u;
		longint v;
		longint re;
		longint rn;
		longint rw;
		longint rs;
		bit sat;
		t = longint'(itau);
		half = longint'(lbd2q4_pkg::HALF_Q15);
		u = longint'($signed(nd.u));
		v = longint'($signed(nd.v));
		c = longint'($signed(nd.e)) + longint'($signed(nd.n)) + longint'($signed(nd.w))
			+ longint'($signed(nd.s));
		sat = 1'b0;
		re = relax_dist(longint'($signed(nd.e)), c, half + u, t, sat);
		rn = relax_dist(longint'($signed(nd.n)), c, half + v, t, sat);
		rw = relax_dist(longint'($signed(nd.w)), c, half - u, t, sat);
		rs = relax_dist(longint'($signed(nd.s)), c, half - v, t, sat);
		r.east = rw[DW-1:0];
		r.north = rs[DW-1:0];
		r.west = re[DW-1:0];
		r.south = rn[DW-1:0];
		r.conc = c[DW+1:0];
		r.sat = sat;
		return r;
	endfunction

	function automatic node_t random_node();
		node_t nd;
		int kind;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2, 3, 4: begin
				nd.e = $urandom_range(32'h02000000);
				nd.n = $urandom_range(32'h02000000);
				nd.w = $urandom_range(32'h02000000);
				nd.s = $urandom_range(32'h02000000);
				nd.u = VW'($urandom_range(8191) - 4096);
				nd.v = VW'($urandom_range(8191) - 4096);
			end
			5, 6: begin
				nd.e = $urandom;
				nd.n = $urandom;
				nd.w = $urandom;
				nd.s = $urandom;
				nd.u = VW'($urandom);
				nd.v = VW'($urandom);
			end
			7: begin
				nd.e = ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000) ^ $urandom_range(255);
				nd.n = ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000) ^ $urandom_range(255);
				nd.w = ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000) ^ $urandom_range(255);
				nd.s = ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000) ^ $urandom_range(255);
				nd.u = VW'(($urandom_range(1) ? 16'h7FFF : 16'h8000) ^ $urandom_range(15));
				nd.v = VW'(($urandom_range(1) ? 16'h7FFF : 16'h8000) ^ $urandom_range(15));
			end
			8: begin
				nd.e = -$urandom_range(32'h02000000);
				nd.n = -$urandom_range(32'h02000000);
				nd.w = -$urandom_range(32'h02000000);
				nd.s = -$urandom_range(32'h02000000);
				nd.u = VW'($urandom_range(8191) - 4096);
				nd.v = VW'($urandom_range(8191) - 4096);
			end
			default: begin
				nd.e = $urandom_range(32'h04000000) - 32'h02000000;
				nd.n = $urandom_range(32'h04000000) - 32'h02000000;
				nd.w = $urandom_range(32'h04000000) - 32'h02000000;
				nd.s = $urandom_range(32'h04000000) - 32'h02000000;
				nd.u = VW'($urandom);
				nd.v = VW'($urandom);
			end
		endcase
		return nd;
	endfunction

	task automatic send_node(input node_t nd, input logic typed, input slots_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			node_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		node_valid <= 1'b1;
		dist_east <= nd.e;
		dist_north <= nd.n;
		dist_west <= nd.w;
		dist_south <= nd.s;
		vel_x <= nd.u;
		vel_y <= nd.v;
		do
			@(posedge clk);
		while (node_stall);
		pending_slots.push_back(typed ? want : collide_node(nd, itau_now));
	endtask

	task automatic run_batch(input int count);
		for (int i = 0; i < count; i++)
			send_node(random_node(), 1'b0, '0);
		node_valid <= 1'b0;
	endtask

	task automatic drain_slots();
		while (pending_slots.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_tau(input logic [ITW-1:0] val);
		drain_slots();
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		itau_now = val;
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		slots_t want;
		if (arst_n && slot_valid && !slot_stall) begin
			if (pending_slots.size() == 0) begin
				mismatch_count++;
				$display("%0t: slot transaction expected none, actual %h", $time, slot_east);
			end else begin
				want = pending_slots.pop_front();
				compare_field("slot_east", want.east, slot_east);
				compare_field("slot_north", want.north, slot_north);
				compare_field("slot_west", want.west, slot_west);
				compare_field("slot_south", want.south, slot_south);
				compare_field("concentration", want.conc, concentration);
				compare_field("saturated", want.sat, saturated);
			end
		end
	end

	initial begin
		slot_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				slot_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				slot_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((node_valid && !node_stall) || (slot_valid && !slot_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [ITW-1:0] taus [8];
		taus = '{17'd0, 17'd131071, 17'd1, 17'd32768, 17'd98304, 17'd65536,
			ITW'($urandom_range(131071)), ITW'($urandom_range(131071))};
		arst_n <= 1'b0;
		node_valid <= 1'b0;
		dist_east <= '0;
		dist_north <= '0;
		dist_west <= '0;
		dist_south <= '0;
		vel_x <= '0;
		vel_y <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (node_rows[i])
			send_node(node_rows[i].node, node_rows[i].typed, node_rows[i].want);
		node_valid <= 1'b0;

		foreach (taus[p]) begin
			write_tau(taus[p]);
			idle_pct = (p == 2) ? 0 : 17;
			if (p == 1)
				hold_req = 1'b1;
			if (p == 3) begin
				run_batch(80);
				drain_slots();
				run_batch(80);
			end else begin
				run_batch(150);
			end
		end

		drain_slots();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
